>>> src/sspg_pkg.sv
// ----------------------------------------------------------------------------
// sspg_pkg: shared types, constants and font for the status screen generator
// Holds the scene geometry, the colour set, the 5x7 font and the rectangle
// hit test used by the pipeline stages.
// ----------------------------------------------------------------------------
package sspg_pkg;

  // Coordinate width: default and upper bound of the COORD_BITS parameter
  localparam int COORD_BITS_DEF = 10;
  localparam int COORD_BITS_MAX = 12;
  // Signed working width for geometry: room for sums and negative offsets
  localparam int CALC_BITS = COORD_BITS_MAX + 2;

  typedef logic signed [CALC_BITS-1:0] calc_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_FRAME_WIDTH   = 2'd0,
    REG_FRAME_HEIGHT  = 2'd1,
    REG_LINK_UP       = 2'd2,
    REG_BATTERY_LEVEL = 2'd3
  } cfg_reg_t;

  localparam int CFG_INDEX_BITS = 2;
  localparam int BATT_BITS      = 7;

  // Reset values of the configuration registers
  localparam int FRAME_WIDTH_RST   = 320;
  localparam int FRAME_HEIGHT_RST  = 240;
  localparam int BATTERY_LEVEL_RST = 127;
  localparam int BATTERY_FULL      = 100;

  // Colours, byte-swapped RGB565
  localparam logic [15:0] COL_BG     = 16'h0000;
  localparam logic [15:0] COL_HULL   = 16'hEF7B;
  localparam logic [15:0] COL_TRACK  = 16'hE73B;
  localparam logic [15:0] COL_GUN    = 16'h00FC;
  localparam logic [15:0] COL_LINK   = 16'hE007;
  localparam logic [15:0] COL_NOLINK = 16'h00F8;
  localparam logic [15:0] COL_TEXT   = 16'hFFFF;

  // Scene geometry
  localparam int HULL_W     = 60;
  localparam int HULL_H     = 40;
  localparam int TUR_W      = 30;
  localparam int TUR_H      = 20;
  localparam int GUN_W      = 40;
  localparam int GUN_H      = 6;
  localparam int TRK_H      = 8;
  localparam int ICON_X     = 280;
  localparam int ICON_Y     = 10;
  localparam int ICON_W     = 20;
  localparam int ICON_H     = 15;
  localparam int TXT_X      = 265;
  localparam int TXT_Y      = 35;
  localparam int GLYPH_STEP = 6;
  localparam int GLYPH_W    = 5;
  localparam int GLYPH_H    = 7;

  // Glyph codes: 0..9 are digits, then the percent sign
  localparam int GLYPH_COUNT = 11;
  localparam logic [3:0] GLYPH_ZERO = 4'd0;
  localparam logic [3:0] GLYPH_ONE  = 4'd1;
  localparam logic [3:0] GLYPH_PCT  = 4'd10;

  // Glyph slots of the readout
  localparam logic [1:0] SLOT_FIRST  = 2'd0;
  localparam logic [1:0] SLOT_SECOND = 2'd1;
  localparam logic [1:0] SLOT_THIRD  = 2'd2;

  // Layer hits of one pixel, lowest layer first
  typedef struct packed {
    logic track;
    logic hull;
    logic gun;
    logic icon;
  } layer_hits_t;

  // Position of one pixel inside the readout
  typedef struct packed {
    logic       in_box;
    logic [1:0] slot;
    logic [2:0] col;
    logic [2:0] row;
  } text_pos_t;

  // 5x7 font, bit 4 is the leftmost column
  localparam logic [0:GLYPH_COUNT-1][0:GLYPH_H-1][GLYPH_W-1:0] FONT = {
    {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h1F, 5'h01, 5'h01, 5'h1F, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h01, 5'h01, 5'h1F, 5'h01, 5'h01, 5'h1F},
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E},
    {5'h19, 5'h19, 5'h04, 5'h08, 5'h13, 5'h13, 5'h00}
  };

  // Row bits of a glyph; codes past the percent sign are blank
  function automatic logic [GLYPH_W-1:0] glyph_row(input logic [3:0] code,
                                                   input logic [2:0] row);
    logic [GLYPH_W-1:0] bits;
    bits = '0;
    if (code <= GLYPH_PCT && row < 3'(GLYPH_H)) begin
      bits = FONT[code][row];
    end
    return bits;
  endfunction

  // Point inside a rectangle that fits wholly in the frame
  function automatic logic rect_hit(input calc_t px, input calc_t py,
                                    input calc_t rx, input calc_t ry,
                                    input calc_t rw, input calc_t rh,
                                    input calc_t fw, input calc_t fh);
    logic fits;
    logic covered;
    fits    = (rx >= 0) && (ry >= 0) && (rx + rw <= fw) && (ry + rh <= fh);
    covered = (px >= rx) && (px < rx + rw) && (py >= ry) && (py < ry + rh);
    return fits && covered;
  endfunction

endpackage

>>> src/sspg_shape_stage.sv
// ----------------------------------------------------------------------------
// sspg_shape_stage: rectangle and readout position stage
// Tests the pixel against every scene rectangle and locates it inside the
// readout; registers the results with the item's valid bit.
// ----------------------------------------------------------------------------
module sspg_shape_stage
  import sspg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  load,
  input  logic                  valid_in,
  input  logic [COORD_BITS-1:0] px,
  input  logic [COORD_BITS-1:0] py,
  input  logic [COORD_BITS-1:0] frame_width,
  input  logic [COORD_BITS-1:0] frame_height,
  output logic                  valid,
  output layer_hits_t           hits,
  output text_pos_t             text_pos
);

  calc_t       x;
  calc_t       y;
  calc_t       fw;
  calc_t       fh;
  calc_t       cx;
  calc_t       cy;
  calc_t       ox;
  calc_t       oy;
  logic        in_frame;
  layer_hits_t hits_next;
  text_pos_t   text_pos_next;

  assign x  = calc_t'(px);
  assign y  = calc_t'(py);
  assign fw = calc_t'(frame_width);
  assign fh = calc_t'(frame_height);
  assign cx = calc_t'(frame_width >> 1);
  assign cy = calc_t'(frame_height >> 1);

  // Test the scene rectangles, merging the ones that share a colour
  always_comb begin
    hits_next.track =
      rect_hit(x, y, cx - calc_t'(HULL_W / 2), cy - calc_t'(HULL_H / 2 + TRK_H),
               calc_t'(HULL_W), calc_t'(TRK_H), fw, fh) ||
      rect_hit(x, y, cx - calc_t'(HULL_W / 2), cy + calc_t'(HULL_H / 2),
               calc_t'(HULL_W), calc_t'(TRK_H), fw, fh);
    hits_next.hull =
      rect_hit(x, y, cx - calc_t'(HULL_W / 2), cy - calc_t'(HULL_H / 2),
               calc_t'(HULL_W), calc_t'(HULL_H), fw, fh) ||
      rect_hit(x, y, cx - calc_t'(TUR_W / 2), cy - calc_t'(TUR_H / 2),
               calc_t'(TUR_W), calc_t'(TUR_H), fw, fh);
    hits_next.gun =
      rect_hit(x, y, cx, cy - calc_t'(GUN_H / 2),
               calc_t'(GUN_W), calc_t'(GUN_H), fw, fh);
    hits_next.icon =
      rect_hit(x, y, calc_t'(ICON_X), calc_t'(ICON_Y),
               calc_t'(ICON_W), calc_t'(ICON_H), fw, fh);
  end

  // Locate the pixel in the readout: glyph slot, column and row
  assign ox       = x - calc_t'(TXT_X);
  assign oy       = y - calc_t'(TXT_Y);
  assign in_frame = (x < fw) && (y < fh);

  always_comb begin
    text_pos_next.in_box = 1'b0;
    text_pos_next.slot   = SLOT_FIRST;
    text_pos_next.col    = ox[2:0];
    text_pos_next.row    = oy[2:0];
    priority if (ox >= 0 && ox < calc_t'(GLYPH_W)) begin
      text_pos_next.in_box = 1'b1;
    end else if (ox >= calc_t'(GLYPH_STEP) && ox < calc_t'(GLYPH_STEP + GLYPH_W)) begin
      text_pos_next.in_box = 1'b1;
      text_pos_next.slot   = SLOT_SECOND;
      text_pos_next.col    = 3'(ox - calc_t'(GLYPH_STEP));
    end else if (ox >= calc_t'(2 * GLYPH_STEP) &&
                 ox < calc_t'(2 * GLYPH_STEP + GLYPH_W)) begin
      text_pos_next.in_box = 1'b1;
      text_pos_next.slot   = SLOT_THIRD;
      text_pos_next.col    = 3'(ox - calc_t'(2 * GLYPH_STEP));
    end else begin
      text_pos_next.in_box = 1'b0;
    end
    // Drop rows outside the glyph box and pixels outside the frame
    if (oy < 0 || oy >= calc_t'(GLYPH_H) || !in_frame) begin
      text_pos_next.in_box = 1'b0;
    end
  end

  // Hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  // Hold the payload
  always_ff @(posedge clk) begin
    if (load) begin
      hits     <= hits_next;
      text_pos <= text_pos_next;
    end
  end

endmodule

>>> src/sspg_text_stage.sv
// ----------------------------------------------------------------------------
// sspg_text_stage: readout glyph and colour resolve stage
// Picks the glyph of the pixel's slot from the battery level, reads its
// font bit and resolves the layers into the output colour register.
// ----------------------------------------------------------------------------
module sspg_text_stage
  import sspg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  logic                 valid_in,
  input  layer_hits_t          hits,
  input  text_pos_t            text_pos,
  input  logic                 link_up,
  input  logic [BATT_BITS-1:0] battery_level,
  output logic                 valid,
  output logic [15:0]          pixel_color
);

  logic [14:0]          tens_prod;
  logic [3:0]           tens;
  logic [BATT_BITS-1:0] tens_x10;
  logic [3:0]           ones;
  logic [3:0]           code;
  logic [GLYPH_W-1:0]   row_bits;
  logic                 text_on;
  logic [15:0]          color_next;

  // Split the level into digits: divide by ten through a reciprocal
  assign tens_prod = 15'(battery_level) * 15'd205;
  assign tens      = tens_prod[14:11];
  assign tens_x10  = BATT_BITS'(tens) * BATT_BITS'(10);
  assign ones      = 4'(battery_level - tens_x10);

  // Choose the glyph of this slot
  always_comb begin
    code = GLYPH_PCT;
    if (battery_level == BATT_BITS'(BATTERY_FULL)) begin
      code = (text_pos.slot == SLOT_FIRST) ? GLYPH_ONE : GLYPH_ZERO;
    end else begin
      unique case (text_pos.slot)
        SLOT_FIRST:  code = tens;
        SLOT_SECOND: code = ones;
        default:     code = GLYPH_PCT;
      endcase
    end
  end

  assign row_bits = glyph_row(code, text_pos.row);
  assign text_on  = text_pos.in_box &&
                    (battery_level <= BATT_BITS'(BATTERY_FULL)) &&
                    row_bits[3'(GLYPH_W - 1) - text_pos.col];

  // Resolve layers, topmost first
  always_comb begin
    priority if (text_on) begin
      color_next = COL_TEXT;
    end else if (hits.icon) begin
      color_next = link_up ? COL_LINK : COL_NOLINK;
    end else if (hits.gun) begin
      color_next = COL_GUN;
    end else if (hits.hull) begin
      color_next = COL_HULL;
    end else if (hits.track) begin
      color_next = COL_TRACK;
    end else begin
      color_next = COL_BG;
    end
  end

  // Hold the valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= valid_in;
    end
  end

  // Hold the colour
  always_ff @(posedge clk) begin
    if (load) begin
      pixel_color <= color_next;
    end
  end

endmodule

>>> src/status_screen_pixel_generator.sv
// ----------------------------------------------------------------------------
// status_screen_pixel_generator: colour of one status screen pixel
// Input register, shape test stage and text/colour stage under a
// valid/ready pipeline, plus the configuration registers.
// ----------------------------------------------------------------------------
// Takes one pixel coordinate per clock while the output side takes results
// and returns its byte-swapped RGB565 colour through the input register,
// the rectangle stage and the text and colour stage, which hold one item
// each; each stage stalls only when the one after it is full and blocked.
// Configuration writes are accepted in every cycle and must be made while
// no item is in flight.
module status_screen_pixel_generator
  import sspg_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COORD_BITS-1:0]     pixel_x,
  input  logic [COORD_BITS-1:0]     pixel_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [15:0]               pixel_color,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0]     cfg_data
);

  logic [COORD_BITS-1:0] frame_width;
  logic [COORD_BITS-1:0] frame_height;
  logic                  link_up;
  logic [BATT_BITS-1:0]  battery_level;

  logic                  in_vld;
  logic [COORD_BITS-1:0] in_x;
  logic [COORD_BITS-1:0] in_y;
  logic                  shape_vld;
  layer_hits_t           shape_hits;
  text_pos_t             shape_text;
  logic                  adv_in;
  logic                  adv_shape;
  logic                  adv_out;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= COORD_BITS'(FRAME_WIDTH_RST);
      frame_height  <= COORD_BITS'(FRAME_HEIGHT_RST);
      link_up       <= 1'b0;
      battery_level <= BATT_BITS'(BATTERY_LEVEL_RST);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FRAME_WIDTH:   frame_width   <= cfg_data;
        REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
        REG_LINK_UP:       link_up       <= cfg_data[0];
        REG_BATTERY_LEVEL: battery_level <= cfg_data[BATT_BITS-1:0];
        default:           ;
      endcase
    end
  end

  // Stage enables: a stage advances when empty or when the next one moves
  assign adv_out   = !out_valid || out_ready;
  assign adv_shape = !shape_vld || adv_out;
  assign adv_in    = !in_vld || adv_shape;
  assign in_ready  = adv_in;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (adv_in) begin
      in_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_in) begin
      in_x <= pixel_x;
      in_y <= pixel_y;
    end
  end

  sspg_shape_stage #(
    .COORD_BITS (COORD_BITS)
  ) u_shape (
    .clk          (clk),
    .rst          (rst),
    .load         (adv_shape),
    .valid_in     (in_vld),
    .px           (in_x),
    .py           (in_y),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .valid        (shape_vld),
    .hits         (shape_hits),
    .text_pos     (shape_text)
  );

  sspg_text_stage u_text (
    .clk           (clk),
    .rst           (rst),
    .load          (adv_out),
    .valid_in      (shape_vld),
    .hits          (shape_hits),
    .text_pos      (shape_text),
    .link_up       (link_up),
    .battery_level (battery_level),
    .valid         (out_valid),
    .pixel_color   (pixel_color)
  );

`ifndef NO_ASSERTIONS
  // Input stalls only when every stage is full and the output is blocked
  a_stall_source: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (in_vld && shape_vld && out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // An item in the input register that may advance reaches the shape stage
  a_in_to_shape: assert property (@(posedge clk) disable iff (rst)
    (in_vld && adv_shape) |=> shape_vld)
    else $error("item lost between input and shape stage");

  // An item in the shape stage that may advance reaches the output
  a_shape_to_out: assert property (@(posedge clk) disable iff (rst)
    (shape_vld && adv_out) |=> out_valid)
    else $error("item lost between shape stage and output");

  // Text colour only appears when the readout is shown
  a_text_level: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_color == COL_TEXT) |->
      (battery_level <= BATT_BITS'(BATTERY_FULL)))
    else $error("text colour with readout hidden");
`endif

endmodule

>>> tb/status_screen_pixel_generator_tb.sv
// ----------------------------------------------------------------------------
// status_screen_pixel_generator_tb: self-checking bench for the pixel generator
// Drives pixel coordinates through the valid/ready input, predicts the colour
// of each one from a local copy of the scene and the registers, and compares
// every returned colour in order. Registers change only with the pipe empty.
// ----------------------------------------------------------------------------
module status_screen_pixel_generator_tb;
  import sspg_pkg::cfg_reg_t;
  import sspg_pkg::REG_FRAME_WIDTH;
  import sspg_pkg::REG_FRAME_HEIGHT;
  import sspg_pkg::REG_LINK_UP;
  import sspg_pkg::REG_BATTERY_LEVEL;

  timeunit 1ns;
  timeprecision 1ps;

  // Scene colours, byte-swapped RGB565
  localparam logic [15:0] BLACK      = 16'h0000;
  localparam logic [15:0] HULL_GREY  = 16'hEF7B;
  localparam logic [15:0] TRACK_GREY = 16'hE73B;
  localparam logic [15:0] GUN_RED    = 16'h00FC;
  localparam logic [15:0] LINK_GREEN = 16'hE007;
  localparam logic [15:0] LINK_RED   = 16'h00F8;
  localparam logic [15:0] TEXT_WHITE = 16'hFFFF;

  // Scene geometry
  localparam int HULL_WIDTH   = 60;
  localparam int HULL_HEIGHT  = 40;
  localparam int TURRET_WIDTH = 30;
  localparam int TURRET_HEIGHT = 20;
  localparam int GUN_LENGTH   = 40;
  localparam int GUN_THICK    = 6;
  localparam int TRACK_THICK  = 8;
  localparam int ICON_LEFT    = 280;
  localparam int ICON_TOP     = 10;
  localparam int ICON_WIDTH   = 20;
  localparam int ICON_HEIGHT  = 15;
  localparam int READOUT_LEFT = 265;
  localparam int READOUT_TOP  = 35;
  localparam int CHAR_PITCH   = 6;
  localparam int FULL_CHARGE  = 100;
  localparam int PERCENT_SIGN = 10;

  // 5x7 font: digits 0..9 then percent, bit 4 is the leftmost column
  localparam logic [0:10][0:6][4:0] FONT_ROWS = {
    {5'h1F, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h1F},
    {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
    {5'h1F, 5'h01, 5'h01, 5'h1F, 5'h10, 5'h10, 5'h1F},
    {5'h1F, 5'h01, 5'h01, 5'h1F, 5'h01, 5'h01, 5'h1F},
    {5'h11, 5'h11, 5'h11, 5'h1F, 5'h01, 5'h01, 5'h01},
    {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h1E},
    {5'h0F, 5'h10, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
    {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
    {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
    {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h01, 5'h1E},
    {5'h19, 5'h19, 5'h04, 5'h08, 5'h13, 5'h13, 5'h00}
  };

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [9:0]  pixel_x;
  logic [9:0]  pixel_y;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] pixel_color;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [9:0]  cfg_data;

  // Local copy of the registers, at their reset values
  logic [9:0]  scr_width  = 10'd320;
  logic [9:0]  scr_height = 10'd240;
  logic        link_flag  = 1'b0;
  logic [6:0]  batt_pct   = 7'd127;

  logic [15:0] colours_due[$];
  int          mismatch_count = 0;
  int          burst_left = 0;
  bit          gaps_on = 1'b1;
  logic [8:0]  stall_tick = '0;

  status_screen_pixel_generator u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (pixel_color),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Point in a rectangle that lies wholly inside the frame
  function automatic bit covers(input int px, input int py, input int rx, input int ry,
                                input int rw, input int rh, input int fw, input int fh);
    if (rx < 0 || ry < 0 || rx + rw > fw || ry + rh > fh) begin
      return 1'b0;
    end
    return px >= rx && px < rx + rw && py >= ry && py < ry + rh;
  endfunction

  // Set pixel of a glyph at column c, row r of its cell
  function automatic bit glyph_lit(input int c, input int r, input int code);
    if (c < 0 || c > 4 || r < 0 || r > 6) begin
      return 1'b0;
    end
    return FONT_ROWS[code][r][4-c];
  endfunction

  // Colour of one pixel under the current register copy
  function automatic logic [15:0] pixel_colour(input logic [9:0] x, input logic [9:0] y);
    int px, py, fw, fh, cx, cy, level;
    int codes[3];
    logic [15:0] col;
    px = int'(x);
    py = int'(y);
    fw = int'(scr_width);
    fh = int'(scr_height);
    cx = fw / 2;
    cy = fh / 2;
    level = int'(batt_pct);
    col = BLACK;
    // paint shapes bottom layer first
    if (covers(px, py, cx - HULL_WIDTH / 2, cy - HULL_HEIGHT / 2 - TRACK_THICK,
               HULL_WIDTH, TRACK_THICK, fw, fh)) col = TRACK_GREY;
    if (covers(px, py, cx - HULL_WIDTH / 2, cy + HULL_HEIGHT / 2,
               HULL_WIDTH, TRACK_THICK, fw, fh)) col = TRACK_GREY;
    if (covers(px, py, cx - HULL_WIDTH / 2, cy - HULL_HEIGHT / 2,
               HULL_WIDTH, HULL_HEIGHT, fw, fh)) col = HULL_GREY;
    if (covers(px, py, cx - TURRET_WIDTH / 2, cy - TURRET_HEIGHT / 2,
               TURRET_WIDTH, TURRET_HEIGHT, fw, fh)) col = HULL_GREY;
    if (covers(px, py, cx, cy - GUN_THICK / 2, GUN_LENGTH, GUN_THICK, fw, fh)) col = GUN_RED;
    if (covers(px, py, ICON_LEFT, ICON_TOP, ICON_WIDTH, ICON_HEIGHT, fw, fh)) begin
      col = link_flag ? LINK_GREEN : LINK_RED;
    end
    // battery text on top, clipped per pixel
    if (level <= FULL_CHARGE && px < fw && py < fh) begin
      if (level == FULL_CHARGE) begin
        codes = '{1, 0, 0};
      end else begin
        codes = '{level / 10, level % 10, PERCENT_SIGN};
      end
      for (int s = 0; s < 3; s++) begin
        if (glyph_lit(px - READOUT_LEFT - s * CHAR_PITCH, py - READOUT_TOP, codes[s])) begin
          col = TEXT_WHITE;
        end
      end
    end
    return col;
  endfunction

  // Coordinate around a centre, held to the 10-bit range
  function automatic logic [9:0] near(input int centre, input int span);
    int v;
    v = centre - span + int'($urandom_range(0, 2 * span));
    if (v < 0) v = 0;
    if (v > 1023) v = 1023;
    return 10'(v);
  endfunction

  // Predict on each accepted item, compare each accepted result
  always @(posedge clk) begin : compare_colour
    logic [15:0] want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        colours_due.push_back(pixel_colour(pixel_x, pixel_y));
      end
      if (out_valid && out_ready) begin
        if (colours_due.size() == 0) begin
          $display("%0t: unexpected pixel_color, expected none, actual %h", $time, pixel_color);
          mismatch_count++;
        end else begin
          want = colours_due.pop_front();
          if (pixel_color !== want) begin
            $display("%0t: pixel_color mismatch, expected %h, actual %h",
                     $time, want, pixel_color);
            mismatch_count++;
          end
        end
      end
    end
  end

  // Stall the output on a rotating pattern: open, random, long stalls, toggling, mostly open
  always @(posedge clk) begin
    stall_tick <= stall_tick + 9'd1;
    case (stall_tick[8:6])
      3'd0, 3'd1: begin
        out_ready <= 1'b1;
      end
      3'd2: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      3'd3: begin
        out_ready <= (stall_tick[3:0] == 4'd0);
      end
      3'd4: begin
        out_ready <= ~stall_tick[0];
      end
      default: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    endcase
  end

  // Send one item, in bursts with random gaps; valid stays high on return
  task automatic send_pixel(input logic [9:0] x, input logic [9:0] y);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    pixel_x  <= x;
    pixel_y  <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Hold the input until every pending colour is back and the pipe is empty
  task automatic drain_pipe();
    in_valid <= 1'b0;
    // let the checker log the item accepted at this edge
    @(posedge clk);
    while (colours_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Write one register with the pipe empty and mirror it locally
  task automatic write_reg(input cfg_reg_t idx, input logic [9:0] value);
    drain_pipe();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:   scr_width  = value;
      REG_FRAME_HEIGHT:  scr_height = value;
      REG_LINK_UP:       link_flag  = value[0];
      REG_BATTERY_LEVEL: batt_pct   = value[6:0];
      default: ;
    endcase
  endtask

  // Shapes, icon and hidden readout under the reset registers
  task automatic test_reset_scene();
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd1023, 10'd1023);
    send_pixel(10'd160, 10'd120);
    send_pixel(10'd130, 10'd92);
    send_pixel(10'd189, 10'd147);
    send_pixel(10'd130, 10'd100);
    send_pixel(10'd145, 10'd110);
    send_pixel(10'd280, 10'd10);
    send_pixel(10'd299, 10'd24);
    send_pixel(10'd267, 10'd35);
    send_pixel(10'd320, 10'd0);
  endtask

  // Readout forms: full charge, two digits with percent, above full
  task automatic test_readout();
    write_reg(REG_LINK_UP, 10'h3FF);
    write_reg(REG_BATTERY_LEVEL, 10'h3E4);
    send_pixel(10'd267, 10'd35);
    send_pixel(10'd265, 10'd35);
    send_pixel(10'd281, 10'd41);
    send_pixel(10'd290, 10'd12);
    write_reg(REG_BATTERY_LEVEL, 10'd0);
    send_pixel(10'd277, 10'd35);
    send_pixel(10'd277, 10'd41);
    send_pixel(10'd279, 10'd37);
    write_reg(REG_BATTERY_LEVEL, 10'd99);
    send_pixel(10'd265, 10'd38);
    send_pixel(10'd266, 10'd38);
    write_reg(REG_BATTERY_LEVEL, 10'd101);
    send_pixel(10'd267, 10'd35);
  endtask

  // Empty frame, then the largest frame
  task automatic test_frame_limits();
    write_reg(REG_BATTERY_LEVEL, 10'd88);
    write_reg(REG_FRAME_WIDTH, 10'd0);
    write_reg(REG_FRAME_HEIGHT, 10'd0);
    send_pixel(10'd0, 10'd0);
    send_pixel(10'd267, 10'd35);
    write_reg(REG_FRAME_WIDTH, 10'd1023);
    write_reg(REG_FRAME_HEIGHT, 10'd1023);
    send_pixel(10'd511, 10'd511);
    send_pixel(10'd1022, 10'd1022);
    send_pixel(10'd1023, 10'd0);
  endtask

  // Random pixels, mostly aimed at readout, scene and icon, over several frame setups
  task automatic test_random_scenes();
    logic [9:0] fw, fh, x, y;
    int level, sel;
    for (int phase = 0; phase < 10; phase++) begin
      case (phase)
        0: begin fw = 10'd320;  fh = 10'd240;  end
        1: begin fw = 10'd1023; fh = 10'd1023; end
        2: begin fw = 10'd1;    fh = 10'd1;    end
        3: begin fw = 10'd300;  fh = 10'd25;   end
        4: begin fw = 10'd80;   fh = 10'd56;   end
        5: begin fw = 10'd299;  fh = 10'd24;   end
        6: begin fw = 10'($urandom_range(1, 1023)); fh = 10'($urandom_range(1, 1023)); end
        default: begin
          fw = 10'($urandom_range(200, 600));
          fh = 10'($urandom_range(60, 500));
        end
      endcase
      if (phase % 4 == 0) level = FULL_CHARGE;
      else if ($urandom_range(0, 9) < 7) level = $urandom_range(0, FULL_CHARGE - 1);
      else level = $urandom_range(FULL_CHARGE + 1, 127);
      if (phase == 9) level = 127;
      write_reg(REG_FRAME_WIDTH, fw);
      write_reg(REG_FRAME_HEIGHT, fh);
      write_reg(REG_LINK_UP, {9'($urandom_range(0, 511)), 1'(phase)});
      write_reg(REG_BATTERY_LEVEL, {3'($urandom_range(0, 7)), 7'(level)});
      gaps_on = (phase % 3 != 2);
      for (int n = 0; n < 80; n++) begin
        sel = $urandom_range(0, 9);
        if (sel < 4) begin
          x = near(READOUT_LEFT + 8, 11);
          y = near(READOUT_TOP + 3, 6);
        end else if (sel < 7) begin
          x = near(int'(fw) / 2, 75);
          y = near(int'(fh) / 2, 40);
        end else if (sel == 7) begin
          x = near(ICON_LEFT + 10, 14);
          y = near(ICON_TOP + 7, 12);
        end else begin
          x = 10'($urandom_range(0, 1023));
          y = 10'($urandom_range(0, 1023));
        end
        send_pixel(x, y);
      end
    end
  endtask

  // Reset, run each test in turn, then drain and report
  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    pixel_x   = '0;
    pixel_y   = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_scene();
    test_readout();
    test_frame_limits();
    test_random_scenes();
    drain_pipe();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
